[sv/tlbpt_pkg.sv]
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared types and fixed field widths of the TLB page-table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int VA_W      = 16;  // virtual and physical address width
  localparam int FRAME_O_W = 8;   // width of the reported frame index
  localparam int TOTAL_W   = 32;  // width of the running totals

  // Reciprocal used to fold the page number into the page table range
  localparam int REC_SH = 24;
  localparam int REC_W  = 21;

  // Per-cycle commands from the sequencer to the TLB array
  typedef struct packed {
    logic lookup;  // compare the page and register hit, slot and frame
    logic update;  // move the page to the newest slot
  } tlbpt_cam_ctl_t;

endpackage

[sv/tlbpt_cam.sv]
// ----------------------------------------------------------------------------
// tlbpt_cam
// TLB slots in age order (slot 0 oldest) with parallel tag compare and
// LRU reorder on update.
// ----------------------------------------------------------------------------
module tlbpt_cam
  import tlbpt_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int PAGE_W  = 8,
  parameter int FRAME_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tlbpt_cam_ctl_t     ctl,
  input  logic [PAGE_W-1:0]  page,
  input  logic [FRAME_W-1:0] upd_frame,
  output logic               hit,
  output logic [FRAME_W-1:0] frame
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [PAGE_W-1:0]  tag_r [ENTRIES];
  logic [FRAME_W-1:0] frm_r [ENTRIES];
  logic [CNT_W-1:0]   fill_r;
  logic               hit_r;
  logic [IDX_W-1:0]   slot_r;
  logic [FRAME_W-1:0] frame_r;

  logic [ENTRIES-1:0] match_c;
  logic [IDX_W-1:0]   slot_c;
  logic [FRAME_W-1:0] frame_c;
  logic               full_c;
  logic [CNT_W-1:0]   rm_pos_c;
  logic [CNT_W-1:0]   top_pos_c;

  // Pages are unique in the TLB, so at most one slot matches: OR the hits.
  always_comb begin
    match_c = '0;
    slot_c  = '0;
    frame_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_c[i] = (CNT_W'(i) < fill_r) && (tag_r[i] == page);
      if (match_c[i]) begin
        slot_c  = slot_c | IDX_W'(i);
        frame_c = frame_c | frm_r[i];
      end
    end
  end

  // Slots from rm_pos up to top_pos shift down; top_pos takes the page.
  always_comb begin
    full_c = (fill_r == CNT_W'(ENTRIES));
    if (hit_r) begin
      rm_pos_c  = CNT_W'(slot_r);
      top_pos_c = fill_r - CNT_W'(1);
    end else if (full_c) begin
      rm_pos_c  = '0;
      top_pos_c = CNT_W'(ENTRIES - 1);
    end else begin
      rm_pos_c  = fill_r;
      top_pos_c = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      hit_r  <= 1'b0;
    end else begin
      if (ctl.lookup) begin
        hit_r <= |match_c;
      end
      if (ctl.update && !hit_r && !full_c) begin
        fill_r <= fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      slot_r  <= slot_c;
      frame_r <= frame_c;
    end
    if (ctl.update) begin
      for (int k = 0; k < ENTRIES - 1; k++) begin
        if (CNT_W'(k) >= rm_pos_c && CNT_W'(k) < top_pos_c) begin
          tag_r[k] <= tag_r[k+1];
          frm_r[k] <= frm_r[k+1];
        end
      end
      tag_r[top_pos_c[IDX_W-1:0]] <= page;
      frm_r[top_pos_c[IDX_W-1:0]] <= upd_frame;
    end
  end

  assign hit   = hit_r;
  assign frame = frame_r;

endmodule

[sv/tlbpt_ptab.sv]
// ----------------------------------------------------------------------------
// tlbpt_ptab
// Page table memory: one {present, frame} word per page, registered read,
// cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module tlbpt_ptab #(
  parameter int PAGE_COUNT = 256,
  parameter int PAGE_W     = 8,
  parameter int WORD_W     = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PAGE_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [PAGE_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  output logic              clearing
);

  logic [WORD_W-1:0] mem [PAGE_COUNT];
  logic [WORD_W-1:0] rd_data_r;
  logic [PAGE_W-1:0] clr_r;
  logic              clearing_r;

  // Sweep one entry per cycle after reset, then release the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_r <= clr_r + PAGE_W'(1);
      if (clr_r == PAGE_W'(PAGE_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

[sv/tlb_page_table_translator_unit.sv]
// ----------------------------------------------------------------------------
// tlb_page_table_translator_unit
// Virtual-to-physical translation through an LRU TLB and a demand-paged
// page table.
// ----------------------------------------------------------------------------
// Drive start with an address whenever busy is low; the beat is taken at
// that edge. After reset busy stays high while the page table sweep marks
// every page absent. Each address then steps through the states ST_PAGE
// (fold the page number into the table range), ST_LOOK (look up TLB and
// page table in parallel; the table memory read is registered) and
// ST_RESOLVE (resolve hit, miss or fault and write back). busy drops in
// ST_RESOLVE, so a new beat can be taken while the last one resolves. The
// result appears on the out_ ports for exactly one cycle with out_valid;
// there is no way to hold it off, so capture it then. The three totals
// count hits, misses and faults including this beat.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 256,
  parameter int OFFSET_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [VA_W-1:0]      in_virtual_address,
  output logic                 out_valid,
  output logic [VA_W-1:0]      out_physical_address,
  output logic [FRAME_O_W-1:0] out_frame_index,
  output logic                 out_tlb_hit,
  output logic                 out_page_fault,
  output logic [TOTAL_W-1:0]   out_hit_total,
  output logic [TOTAL_W-1:0]   out_miss_total,
  output logic [TOTAL_W-1:0]   out_fault_total
);

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int WORD_W  = FRAME_W + 1;
  localparam int VPN_W   = (VA_W - OFFSET_BITS > 0) ? VA_W - OFFSET_BITS : 1;
  localparam int PROD_W  = VPN_W + REC_W;
  localparam int MOD_W   = PROD_W + 13;
  localparam int REC_MUL = (1 << REC_SH) / PAGE_COUNT;
  localparam logic [VA_W:0] OFF_MASK_W = (VA_W+1)'((1 << OFFSET_BITS) - 1);
  localparam logic [VA_W-1:0] OFF_MASK = OFF_MASK_W[VA_W-1:0];

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAGE,
    ST_LOOK,
    ST_RESOLVE
  } state_t;

  state_t                state_r;
  logic [VA_W-1:0]       va_r;
  logic [PROD_W-1:0]     prod_r;
  logic [PAGE_W-1:0]     page_r;
  logic [FRAME_W-1:0]    nff_r;
  logic [TOTAL_W-1:0]    hit_cnt_r;
  logic [TOTAL_W-1:0]    miss_cnt_r;
  logic [TOTAL_W-1:0]    fault_cnt_r;
  logic                  out_valid_r;
  logic [VA_W-1:0]       out_pa_r;
  logic [FRAME_O_W-1:0]  out_frame_r;
  logic                  out_hit_r;
  logic                  out_fault_r;
  logic [TOTAL_W-1:0]    out_hit_tot_r;
  logic [TOTAL_W-1:0]    out_miss_tot_r;
  logic [TOTAL_W-1:0]    out_fault_tot_r;

  logic                  accept;
  logic                  clearing;
  logic [VPN_W-1:0]      vpn_in;
  logic [VPN_W-1:0]      vpn_r;
  logic [PROD_W-1:0]     quot_c;
  logic [MOD_W-1:0]      rem_c;
  logic [MOD_W-1:0]      rem_fix_c;
  tlbpt_cam_ctl_t        cam_ctl;
  logic                  cam_hit;
  logic [FRAME_W-1:0]    cam_frame;
  logic [WORD_W-1:0]     pt_rd;
  logic                  pt_present;
  logic                  fault_c;
  logic [FRAME_W-1:0]    frame_c;
  logic [FRAME_W-1:0]    nff_nxt;
  logic [TOTAL_W-1:0]    hit_cnt_nxt;
  logic [TOTAL_W-1:0]    miss_cnt_nxt;
  logic [TOTAL_W-1:0]    fault_cnt_nxt;
  logic [VA_W+FRAME_W-1:0] frame_sh_c;

  // Hold busy through the table sweep and the fold and lookup cycles.
  assign busy   = clearing || (state_r == ST_PAGE) || (state_r == ST_LOOK);
  assign accept = start && !busy;

  assign vpn_in = VPN_W'(in_virtual_address >> OFFSET_BITS);
  assign vpn_r  = VPN_W'(va_r >> OFFSET_BITS);

  // Page number modulo PAGE_COUNT: reciprocal quotient is at most one low,
  // so one compare and subtract finishes the remainder.
  always_comb begin
    quot_c    = PROD_W'(prod_r >> REC_SH);
    rem_c     = MOD_W'(vpn_r) - MOD_W'(quot_c) * MOD_W'(PAGE_COUNT);
    rem_fix_c = (rem_c >= MOD_W'(PAGE_COUNT)) ? rem_c - MOD_W'(PAGE_COUNT) : rem_c;
  end

  assign cam_ctl.lookup = (state_r == ST_LOOK);
  assign cam_ctl.update = (state_r == ST_RESOLVE);

  // Resolve: TLB hit wins, else a present page, else assign the next frame.
  always_comb begin
    pt_present    = pt_rd[FRAME_W];
    fault_c       = !cam_hit && !pt_present;
    if (cam_hit) begin
      frame_c = cam_frame;
    end else if (pt_present) begin
      frame_c = pt_rd[FRAME_W-1:0];
    end else begin
      frame_c = nff_r;
    end
    nff_nxt       = (nff_r == FRAME_W'(FRAME_COUNT - 1)) ? '0 : nff_r + FRAME_W'(1);
    hit_cnt_nxt   = hit_cnt_r + TOTAL_W'(cam_hit);
    miss_cnt_nxt  = miss_cnt_r + TOTAL_W'(!cam_hit);
    fault_cnt_nxt = fault_cnt_r + TOTAL_W'(fault_c);
    frame_sh_c    = (VA_W+FRAME_W)'(frame_c) << OFFSET_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nff_r       <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_PAGE;
          end
        end
        ST_PAGE: begin
          state_r <= ST_LOOK;
        end
        ST_LOOK: begin
          state_r <= ST_RESOLVE;
        end
        ST_RESOLVE: begin
          // Commit the beat and take the next one in the same cycle.
          state_r         <= accept ? ST_PAGE : ST_IDLE;
          hit_cnt_r       <= hit_cnt_nxt;
          miss_cnt_r      <= miss_cnt_nxt;
          fault_cnt_r     <= fault_cnt_nxt;
          if (fault_c) begin
            nff_r <= nff_nxt;
          end
          out_valid_r     <= 1'b1;
          out_pa_r        <= frame_sh_c[VA_W-1:0] | (va_r & OFF_MASK);
          out_frame_r     <= FRAME_O_W'(frame_c);
          out_hit_r       <= cam_hit;
          out_fault_r     <= fault_c;
          out_hit_tot_r   <= hit_cnt_nxt;
          out_miss_tot_r  <= miss_cnt_nxt;
          out_fault_tot_r <= fault_cnt_nxt;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (accept) begin
        va_r   <= in_virtual_address;
        prod_r <= PROD_W'(vpn_in) * PROD_W'(REC_MUL);
      end
      if (state_r == ST_PAGE) begin
        page_r <= rem_fix_c[PAGE_W-1:0];
      end
    end
  end

  tlbpt_cam #(
    .ENTRIES (TLB_ENTRIES),
    .PAGE_W  (PAGE_W),
    .FRAME_W (FRAME_W)
  ) u_cam (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (cam_ctl),
    .page      (page_r),
    .upd_frame (frame_c),
    .hit       (cam_hit),
    .frame     (cam_frame)
  );

  // Read in the lookup cycle, write back in resolve; the next read of the
  // table comes in the next beat's lookup, after its fold, so no forwarding is needed.
  tlbpt_ptab #(
    .PAGE_COUNT (PAGE_COUNT),
    .PAGE_W     (PAGE_W),
    .WORD_W     (WORD_W)
  ) u_ptab (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (page_r),
    .rd_data  (pt_rd),
    .wr_en    ((state_r == ST_RESOLVE) && fault_c),
    .wr_addr  (page_r),
    .wr_data  ({1'b1, nff_r}),
    .clearing (clearing)
  );

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_frame_index      = out_frame_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_page_fault       = out_fault_r;
  assign out_hit_total        = out_hit_tot_r;
  assign out_miss_total       = out_miss_tot_r;
  assign out_fault_total      = out_fault_tot_r;

endmodule

[verif/tb_tlb_page_table_translator_unit.sv]
// ----------------------------------------------------------------------------
// tb_tlb_page_table_translator_unit
// Self-checking bench for the TLB page-table translator. It drives virtual
// addresses through the start/busy command port and keeps its own copy of the
// LRU TLB, the demand-paged page table and the running totals. Every out_valid
// beat is compared field by field against the oldest predicted translation.
// A short table of directed addresses comes first, then about 1230 random
// addresses drawn from a drifting working set, with random sender gaps.
// ----------------------------------------------------------------------------
module tb_tlb_page_table_translator_unit
  import tlbpt_pkg::*;
;

  // Block configuration, kept at the default parameter values
  localparam int TLB_DEPTH   = 16;
  localparam int PAGE_NUM    = 256;
  localparam int FRAME_NUM   = 256;
  localparam int OFF_W       = 8;
  localparam int PAGE_W      = VA_W - OFF_W;

  localparam int N_DIRECTED  = 23;
  localparam int N_RANDOM    = 1230;
  localparam int CALM_TAIL   = 150;      // final random beats sent back to back
  localparam int IDLE_MAX    = 18;
  localparam int WSET_SPAN   = 20;       // working set a bit wider than the TLB
  localparam int DRAIN_WAIT  = 9;        // settling time for a stray result beat
  localparam int REPORT_MAX  = 10;
  localparam int CYCLE_LIMIT = 300000;

  // One translation as it shows up on the out_ ports
  typedef struct packed {
    logic [VA_W-1:0]      phys;
    logic [FRAME_O_W-1:0] frame;
    logic                 hit;
    logic                 fault;
    logic [TOTAL_W-1:0]   hits;
    logic [TOTAL_W-1:0]   misses;
    logic [TOTAL_W-1:0]   faults;
  } xlat_t;

  // One row of the directed table; pinned rows carry a hand-written result
  typedef struct {
    logic [VA_W-1:0] va;
    bit              pinned;
    xlat_t           want;
  } addr_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [VA_W-1:0]      in_virtual_address;
  logic                 out_valid;
  logic [VA_W-1:0]      out_physical_address;
  logic [FRAME_O_W-1:0] out_frame_index;
  logic                 out_tlb_hit;
  logic                 out_page_fault;
  logic [TOTAL_W-1:0]   out_hit_total;
  logic [TOTAL_W-1:0]   out_miss_total;
  logic [TOTAL_W-1:0]   out_fault_total;

  tlb_page_table_translator_unit #(
    .TLB_ENTRIES (TLB_DEPTH),
    .PAGE_COUNT  (PAGE_NUM),
    .FRAME_COUNT (FRAME_NUM),
    .OFFSET_BITS (OFF_W)
  ) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_virtual_address   (in_virtual_address),
    .out_valid            (out_valid),
    .out_physical_address (out_physical_address),
    .out_frame_index      (out_frame_index),
    .out_tlb_hit          (out_tlb_hit),
    .out_page_fault       (out_page_fault),
    .out_hit_total        (out_hit_total),
    .out_miss_total       (out_miss_total),
    .out_fault_total      (out_fault_total)
  );

  // --------------------------------------------------------------------------
  // Shadow state of the translator
  // --------------------------------------------------------------------------
  // TLB kept in age order: slot 0 is the oldest, slot tlb_used-1 the newest.
  logic [PAGE_W-1:0]    tlb_page[TLB_DEPTH];
  logic [FRAME_O_W-1:0] tlb_frame[TLB_DEPTH];
  int unsigned          tlb_used;
  logic [FRAME_O_W-1:0] pt_frame[PAGE_NUM];
  bit                   pt_present[PAGE_NUM];
  logic [8:0]           free_frame;
  logic [TOTAL_W-1:0]   hit_cnt;
  logic [TOTAL_W-1:0]   miss_cnt;
  logic [TOTAL_W-1:0]   fault_cnt;

  xlat_t       expected_xlat_q[$];
  addr_row_t   addr_table[N_DIRECTED];
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Translate one address and advance the shadow state, as the block does
  // once it takes the beat.
  function automatic xlat_t translate_va(logic [VA_W-1:0] va);
    logic [PAGE_W-1:0]    page;
    logic [FRAME_O_W-1:0] frame;
    bit                   hit;
    bit                   fault;
    int unsigned          slot;
    xlat_t                res;
    page  = va[VA_W-1:OFF_W];
    frame = '0;
    hit   = 1'b0;
    fault = 1'b0;
    slot  = 0;
    // Only slots below tlb_used are valid, so an empty TLB never hits page 0
    for (int i = 0; i < tlb_used; i++) begin
      if (!hit && tlb_page[i] == page) begin
        hit   = 1'b1;
        slot  = i;
        frame = tlb_frame[i];
      end
    end
    if (hit) begin
      hit_cnt++;
    end else begin
      miss_cnt++;
      if (pt_present[page]) begin
        frame = pt_frame[page];
      end else begin
        // Demand paging: hand out frames in order, wrapping after the last
        fault = 1'b1;
        fault_cnt++;
        frame = free_frame[FRAME_O_W-1:0];
        pt_frame[page]   = frame;
        pt_present[page] = 1'b1;
        free_frame = (free_frame == FRAME_NUM - 1) ? '0 : free_frame + 1'b1;
      end
    end
    // Move the page to the newest slot; on a full TLB drop the oldest
    if (hit) begin
      for (int k = slot; k + 1 < tlb_used; k++) begin
        tlb_page[k]  = tlb_page[k + 1];
        tlb_frame[k] = tlb_frame[k + 1];
      end
      tlb_used--;
    end else if (tlb_used == TLB_DEPTH) begin
      for (int k = 0; k + 1 < TLB_DEPTH; k++) begin
        tlb_page[k]  = tlb_page[k + 1];
        tlb_frame[k] = tlb_frame[k + 1];
      end
      tlb_used = TLB_DEPTH - 1;
    end
    tlb_page[tlb_used]  = page;
    tlb_frame[tlb_used] = frame;
    tlb_used++;
    res.phys   = {frame, va[OFF_W-1:0]};
    res.frame  = frame;
    res.hit    = hit;
    res.fault  = fault;
    res.hits   = hit_cnt;
    res.misses = miss_cnt;
    res.faults = fault_cnt;
    return res;
  endfunction

  // Directed row with a result read straight off the spec
  function automatic addr_row_t pinned_row(logic [VA_W-1:0] va, logic [VA_W-1:0] phys,
                                           logic [FRAME_O_W-1:0] frame, logic hit,
                                           logic fault, int hits, int misses,
                                           int faults);
    addr_row_t row;
    row.va          = va;
    row.pinned      = 1'b1;
    row.want.phys   = phys;
    row.want.frame  = frame;
    row.want.hit    = hit;
    row.want.fault  = fault;
    row.want.hits   = hits;
    row.want.misses = misses;
    row.want.faults = faults;
    return row;
  endfunction

  // Directed row left to the shadow model
  function automatic addr_row_t model_row(logic [VA_W-1:0] va);
    addr_row_t row;
    row.va     = va;
    row.pinned = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run; the limit is many times the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL tlb_page_table_translator_unit");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result checking: every out_valid beat pairs with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
                 cycle_count, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    xlat_t want;
    if (rst_n && out_valid) begin
      if (expected_xlat_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("mismatch at cycle %0d: unexpected result beat, pa 0x%0h",
                   cycle_count, out_physical_address);
      end else begin
        want = expected_xlat_q.pop_front();
        check_field("physical_address", TOTAL_W'(want.phys),
                    TOTAL_W'(out_physical_address));
        check_field("frame_index", TOTAL_W'(want.frame), TOTAL_W'(out_frame_index));
        check_field("tlb_hit", TOTAL_W'(want.hit), TOTAL_W'(out_tlb_hit));
        check_field("page_fault", TOTAL_W'(want.fault), TOTAL_W'(out_page_fault));
        check_field("hit_total",        want.hits,   out_hit_total);
        check_field("miss_total",       want.misses, out_miss_total);
        check_field("fault_total",      want.faults, out_fault_total);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Present one address from a falling edge and hold it until a rising edge
  // sees busy low. Return at the next falling edge with start still high, so
  // a following beat can go out without a gap.
  task automatic send_addr(logic [VA_W-1:0] va, bit pinned, xlat_t pinned_want);
    xlat_t predicted;
    start              <= 1'b1;
    in_virtual_address <= va;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Advance the shadow state on every beat, pinned or not
    predicted = translate_va(va);
    expected_xlat_q.push_back(pinned ? pinned_want : predicted);
    @(negedge clk);
  endtask

  // Drop start for a burst of cycles; called at a falling edge
  task automatic hold_off(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  initial begin
    logic [PAGE_W-1:0] ws_base;
    logic [PAGE_W-1:0] recent_page[4];
    logic [PAGE_W-1:0] page;
    bit                gaps_on;
    xlat_t             none;

    rst_n              = 1'b0;
    start              = 1'b0;
    in_virtual_address = '0;
    mismatch_count     = 0;
    cycle_count        = 0;
    tlb_used           = 0;
    free_frame         = '0;
    hit_cnt            = '0;
    miss_cnt           = '0;
    fault_cnt          = '0;
    none               = '0;
    ws_base            = '0;
    gaps_on            = 1'b0;
    foreach (pt_present[p]) pt_present[p] = 1'b0;
    foreach (recent_page[r]) recent_page[r] = '0;

    // Empty TLB on page 0, both address extremes, then back-to-back hits and
    // fresh faults. Rows 7..18 fill the TLB to capacity, row 19 evicts page 0,
    // row 20 brings page 0 back as a miss on a present page with no fault,
    // row 21 hits an entry from the middle of the age order.
    addr_table = '{
      pinned_row(16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, 0, 1, 1),
      pinned_row(16'hFFFF, 16'h01FF, 8'h01, 1'b0, 1'b1, 0, 2, 2),
      pinned_row(16'h00FF, 16'h00FF, 8'h00, 1'b1, 1'b0, 1, 2, 2),
      pinned_row(16'hFF00, 16'h0100, 8'h01, 1'b1, 1'b0, 2, 2, 2),
      pinned_row(16'h8000, 16'h0200, 8'h02, 1'b0, 1'b1, 2, 3, 3),
      pinned_row(16'h7FFF, 16'h03FF, 8'h03, 1'b0, 1'b1, 2, 4, 4),
      model_row(16'h0101), model_row(16'h0202), model_row(16'h0303),
      model_row(16'h0404), model_row(16'h0505), model_row(16'h0606),
      model_row(16'h0707), model_row(16'h0808), model_row(16'h0909),
      model_row(16'h0A0A), model_row(16'h0B0B), model_row(16'h0C0C),
      model_row(16'h0DAA),
      model_row(16'h0055),
      model_row(16'h0C3C),
      model_row(16'h5555),
      model_row(16'hAAAA)
    };

    // Hold reset, then release it; the block sweeps its page table while
    // busy is high, which send_addr simply waits out.
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (addr_table[i])
      send_addr(addr_table[i].va, addr_table[i].pinned, addr_table[i].want);

    // Random part: mostly a 20-page working set that drifts one page every
    // four beats, so hits, LRU reorders and evictions all happen, and over
    // the run every page faults once and the free-frame counter wraps.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0)
        gaps_on = ($urandom_range(0, 2) != 0);
      if (n >= N_RANDOM - CALM_TAIL)
        gaps_on = 1'b0;
      if (gaps_on && $urandom_range(0, 2) == 0)
        hold_off($urandom_range(1, IDLE_MAX));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: page = ws_base + PAGE_W'($urandom_range(0, WSET_SPAN - 1));
        6, 7:             page = recent_page[$urandom_range(0, 3)];
        default:          page = PAGE_W'($urandom_range(0, PAGE_NUM - 1));
      endcase
      recent_page[n % 4] = page;
      if (n % 4 == 3)
        ws_base++;
      send_addr({page, OFF_W'($urandom_range(0, (1 << OFF_W) - 1))}, 1'b0, none);
    end
    start <= 1'b0;

    // Drain outstanding results, then give a stray beat time to show up
    while (expected_xlat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS tlb_page_table_translator_unit");
    end else begin
      $display("FAIL tlb_page_table_translator_unit");
    end
    $finish;
  end

endmodule
